>>> src/aci_pkg.sv
package aci_pkg;

	// fourcc tags, packed little endian
	localparam logic [31:0] TAG_AUDIO = 32'h6277_3130;
	localparam logic [31:0] TAG_VIDEO = 32'h6364_3030;

	// key frame detection
	localparam logic [7:0] KEY_PROBE = 8'h67;
	localparam logic [4:0] KEY_FLAG  = 5'h10;

	// offset bias and chunk header length
	localparam logic [31:0] OFFSET_BIAS = 32'd4;
	localparam logic [31:0] CHUNK_HDR   = 32'd8;

	// rate arithmetic: size * 1e6 fits in 52 bits
	localparam int unsigned    US_W    = 20;
	localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
	localparam int unsigned    TS_W    = 48;
	localparam int unsigned    DIV_W   = 52;
	localparam int unsigned    CNT_W   = 6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic mul;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

>>> src/aci_ctrl.sv
module aci_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  aci_pkg::sts_t sts,
	output aci_pkg::cmd_t cmd,
	output logic          idle
);

	aci_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aci_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aci_pkg::ST_IDLE: begin
				if (in_valid) state_d = aci_pkg::ST_MUL;
			end
			aci_pkg::ST_MUL: begin
				state_d = sts.need_div ? aci_pkg::ST_DIV : aci_pkg::ST_FIN;
			end
			aci_pkg::ST_DIV: begin
				if (sts.div_last) state_d = aci_pkg::ST_FIN;
			end
			aci_pkg::ST_FIN: begin
				if (sts.out_free) state_d = aci_pkg::ST_IDLE;
			end
			default: state_d = aci_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		unique case (state_q)
			aci_pkg::ST_IDLE: begin
				idle        = 1'b1;
				cmd.load_in = in_valid;
			end
			aci_pkg::ST_MUL: cmd.mul      = 1'b1;
			aci_pkg::ST_DIV: cmd.div_step = 1'b1;
			aci_pkg::ST_FIN: cmd.finish   = sts.out_free;
			default: cmd = '0;
		endcase
	end

	// division steps only follow the multiply or another step
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> $past(cmd.mul) || $past(cmd.div_step))
		else $error("divide step out of sequence");

	// no division when the peak update is skipped
	a_skip_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul && !sts.need_div |=> !cmd.div_step)
		else $error("divider started on skipped peak update");

	// a result is written only into a free output slot
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result overwrote pending output");

endmodule

>>> src/aci_dp.sv
module aci_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  aci_pkg::cmd_t cmd,
	output aci_pkg::sts_t sts,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_data,
	input  logic          is_audio,
	input  logic [47:0]   timestamp_us,
	input  logic [31:0]   frame_bytes,
	input  logic [7:0]    probe_byte,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [31:0]   chunk_id,
	output logic [4:0]    key_flags,
	output logic [31:0]   chunk_offset,
	output logic [31:0]   chunk_size,
	output logic          pad_byte,
	output logic [31:0]   bytes_total,
	output logic [31:0]   video_frames,
	output logic [31:0]   audio_frames,
	output logic [32:0]   peak_rate_sum
);

	localparam int unsigned TW = aci_pkg::TS_W;
	localparam int unsigned DW = aci_pkg::DIV_W;
	localparam int unsigned CW = aci_pkg::CNT_W;

	// captured item
	logic          audio_q;
	logic [TW-1:0] ts_q;
	logic [31:0]   size_q;
	logic [7:0]    probe_q;

	// running state
	logic [TW-1:0] last_audio_q, last_video_q;
	logic [31:0]   audio_peak_q, video_peak_q;
	logic [31:0]   written_q, audio_cnt_q, video_cnt_q;

	// divider
	logic [DW-1:0] dvd_q;
	logic [TW-1:0] rem_q, delta_q;
	logic [CW-1:0] cnt_q;

	logic          out_valid_q;

	logic [TW-1:0] last_sel;
	logic [DW-1:0] prod;
	logic [TW:0]   trial, diff;
	logic          ge;
	logic [31:0]   rate;
	logic [31:0]   audio_peak_d, video_peak_d;
	logic [31:0]   written_d;
	logic [31:0]   pad_ext;

	// peak update is taken only with a stored time and a positive delta
	assign last_sel     = audio_q ? last_audio_q : last_video_q;
	assign sts.need_div = (last_sel != '0) && (ts_q > last_sel);
	assign sts.div_last = (cnt_q == CW'(DW - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	// size times one million, registered into the dividend
	assign prod = DW'(size_q) * DW'(aci_pkg::US_PER_S);

	// restoring divide step
	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, delta_q};
	assign diff  = trial - {1'b0, delta_q};

	// saturate quotient to 32 bits
	assign rate = (|dvd_q[DW-1:32]) ? 32'hFFFF_FFFF : dvd_q[31:0];

	// new peaks
	always_comb begin
		audio_peak_d = audio_peak_q;
		video_peak_d = video_peak_q;
		if (sts.need_div) begin
			if (audio_q && rate > audio_peak_q) audio_peak_d = rate;
			if (!audio_q && rate > video_peak_q) video_peak_d = rate;
		end
	end

	assign pad_ext   = {31'd0, size_q[0]};
	assign written_d = written_q + aci_pkg::CHUNK_HDR + size_q + pad_ext;

	// item capture and divider
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			audio_q <= is_audio;
			ts_q    <= timestamp_us;
			size_q  <= frame_bytes;
			probe_q <= probe_byte;
		end
		if (cmd.mul) begin
			dvd_q   <= prod;
			rem_q   <= '0;
			delta_q <= ts_q - last_sel;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
			dvd_q <= {dvd_q[DW-2:0], ge};
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// running totals, peaks and stored times
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_audio_q <= '0;
			last_video_q <= '0;
			audio_peak_q <= '0;
			video_peak_q <= '0;
			written_q    <= '0;
			audio_cnt_q  <= '0;
			video_cnt_q  <= '0;
		end else if (cfg_we) begin
			written_q <= cfg_data;
		end else if (cmd.finish) begin
			audio_peak_q <= audio_peak_d;
			video_peak_q <= video_peak_d;
			written_q    <= written_d;
			if (audio_q) begin
				last_audio_q <= ts_q;
				audio_cnt_q  <= audio_cnt_q + 32'd1;
			end else begin
				last_video_q <= ts_q;
				video_cnt_q  <= video_cnt_q + 32'd1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			chunk_id      <= audio_q ? aci_pkg::TAG_AUDIO : aci_pkg::TAG_VIDEO;
			key_flags     <= (probe_q == aci_pkg::KEY_PROBE) ? aci_pkg::KEY_FLAG : 5'd0;
			chunk_offset  <= written_q + aci_pkg::OFFSET_BIAS;
			chunk_size    <= size_q;
			pad_byte      <= size_q[0];
			bytes_total   <= written_d;
			video_frames  <= audio_q ? video_cnt_q : video_cnt_q + 32'd1;
			audio_frames  <= audio_q ? audio_cnt_q + 32'd1 : audio_cnt_q;
			peak_rate_sum <= {1'b0, audio_peak_d} + {1'b0, video_peak_d};
		end
	end

	assign out_valid = out_valid_q;

	// a new result appears only from a finish command
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output valid without finished item");

endmodule

>>> src/avi_chunk_indexer_top.sv
// AVI idx1 index entry generator. Each frame item (type, timestamp, size,
// probe byte) yields one index entry with running byte count, per-type frame
// counts and the sum of the per-type peak byte rates. When the peak rate is
// updated, the item passes through the multiply state, the bit-serial
// restoring divider that forms size*1000000/delta, and the write state.
// The next item can be accepted in the cycle after the write. When the
// frame has no nonzero earlier timestamp of its type or a non-positive
// delta, the divider is skipped and the item goes from the multiply state
// straight to the write state. One item is in flight at a time; the next
// item is taken while the previous result still waits in the output
// register, and a finished item waits in its write cycle while that
// register is still stalled. The start offset register may be written
// whenever cfg_ready is high.
module avi_chunk_indexer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        is_audio,
	input  logic [47:0] timestamp_us,
	input  logic [31:0] frame_bytes,
	input  logic [7:0]  probe_byte,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] chunk_id,
	output logic [4:0]  key_flags,
	output logic [31:0] chunk_offset,
	output logic [31:0] chunk_size,
	output logic        pad_byte,
	output logic [31:0] bytes_total,
	output logic [31:0] video_frames,
	output logic [31:0] audio_frames,
	output logic [32:0] peak_rate_sum
);

	aci_pkg::cmd_t cmd;
	aci_pkg::sts_t sts;
	logic          idle;

	assign in_stall  = !idle;
	assign cfg_ready = idle;

	aci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	aci_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.is_audio      (is_audio),
		.timestamp_us  (timestamp_us),
		.frame_bytes   (frame_bytes),
		.probe_byte    (probe_byte),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.chunk_id      (chunk_id),
		.key_flags     (key_flags),
		.chunk_offset  (chunk_offset),
		.chunk_size    (chunk_size),
		.pad_byte      (pad_byte),
		.bytes_total   (bytes_total),
		.video_frames  (video_frames),
		.audio_frames  (audio_frames),
		.peak_rate_sum (peak_rate_sum)
	);

endmodule

>>> verif/tb_avi_chunk_indexer_top.sv
`timescale 1ns / 100ps

module tb_avi_chunk_indexer_top;

	localparam logic KIND_AUDIO = 1'b1;
	localparam logic KIND_VIDEO = 1'b0;

	localparam int RESET_CYCLES  = 10;
	localparam int ITEM_LATENCY  = 55;
	localparam int SETTLE_CYCLES = ITEM_LATENCY + 10;
	localparam int QUIET_LIMIT   = 4000;
	localparam int LEAD_ROWS     = 11;
	localparam int PLAN_ROWS     = 15;
	localparam int PHASES        = 4;
	localparam int PHASE_ITEMS   = 385;
	localparam int HOLD_AFTER    = 300;
	localparam int HOLD_CYCLES   = 400;

	// one idx1 entry plus the running totals
	typedef struct packed {
		logic [31:0] chunk_id;
		logic [4:0]  key_flags;
		logic [31:0] chunk_offset;
		logic [31:0] chunk_size;
		logic        pad_byte;
		logic [31:0] bytes_total;
		logic [31:0] video_frames;
		logic [31:0] audio_frames;
		logic [32:0] peak_rate_sum;
	} index_entry_t;

	typedef struct packed {
		logic         audio;
		logic [47:0]  ts;
		logic [31:0]  bytes;
		logic [7:0]   probe;
		logic         typed;
		index_entry_t entry;
	} frame_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        is_audio;
	logic [47:0] timestamp_us;
	logic [31:0] frame_bytes;
	logic [7:0]  probe_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] chunk_id;
	logic [4:0]  key_flags;
	logic [31:0] chunk_offset;
	logic [31:0] chunk_size;
	logic        pad_byte;
	logic [31:0] bytes_total;
	logic [31:0] video_frames;
	logic [31:0] audio_frames;
	logic [32:0] peak_rate_sum;

	avi_chunk_indexer_top dut (.*);

	// predictor state
	logic [47:0] last_audio_ts;
	logic [47:0] last_video_ts;
	logic [31:0] audio_peak;
	logic [31:0] video_peak;
	logic [31:0] byte_count;
	logic [31:0] audio_count;
	logic [31:0] video_count;

	index_entry_t pending_entries[$];
	int mismatches = 0;
	int sent = 0;
	int taken = 0;

	// directed frames; the saturating rows run after the random part since
	// peaks never fall once they reach the ceiling
	frame_row_t frame_plan [PLAN_ROWS] = '{
		'{KIND_VIDEO, 48'd0, 32'd0, 8'h00, 1'b1,
			'{aci_pkg::TAG_VIDEO, 5'd0, 32'd4, 32'd0, 1'b0, 32'd8, 32'd1, 32'd0,
				33'd0}},
		'{KIND_AUDIO, 48'd0, 32'd1, aci_pkg::KEY_PROBE, 1'b1,
			'{aci_pkg::TAG_AUDIO, aci_pkg::KEY_FLAG, 32'd12, 32'd1, 1'b1, 32'd18,
				32'd1, 32'd1, 33'd0}},
		// no previous audio time
		'{KIND_AUDIO, 48'd1000, 32'd5, 8'h66, 1'b0, '0},
		'{KIND_AUDIO, 48'd2000, 32'd1000, 8'h68, 1'b0, '0},
		// zero delta, then backward delta
		'{KIND_AUDIO, 48'd2000, 32'd7, aci_pkg::KEY_PROBE, 1'b0, '0},
		'{KIND_AUDIO, 48'd1500, 32'd9, 8'h00, 1'b0, '0},
		// zero timestamp is stored, next frame has no previous time
		'{KIND_AUDIO, 48'd0, 32'd2, 8'hFF, 1'b0, '0},
		'{KIND_AUDIO, 48'd5, 32'd3, 8'h01, 1'b0, '0},
		'{KIND_AUDIO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, aci_pkg::KEY_PROBE, 1'b0, '0},
		'{KIND_VIDEO, 48'd1, 32'h8000_0000, 8'h80, 1'b0, '0},
		'{KIND_VIDEO, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 8'h7F, 1'b0, '0},
		// rate overflow on both types
		'{KIND_VIDEO, 48'h0000_0001_0000, 32'h1234_5678, 8'h10, 1'b0, '0},
		'{KIND_VIDEO, 48'h0000_0001_0001, 32'hFFFF_FFFF, aci_pkg::KEY_PROBE, 1'b0, '0},
		'{KIND_AUDIO, 48'h0000_0002_0000, 32'h0000_0400, 8'h20, 1'b0, '0},
		'{KIND_AUDIO, 48'h0000_0002_0001, 32'hFFFF_FFFE, 8'h40, 1'b0, '0}
	};

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected entry for one frame; advances the predictor state
	function automatic index_entry_t index_frame(input logic audio, input logic [47:0] ts,
			input logic [31:0] bytes, input logic [7:0] probe);
		index_entry_t e;
		logic [47:0]  prev;
		logic [63:0]  rate;
		prev = (audio == KIND_AUDIO) ? last_audio_ts : last_video_ts;
		rate = '0;
		if (prev != 48'd0 && ts > prev) begin
			rate = ({32'd0, bytes} * 64'(aci_pkg::US_PER_S)) / {16'd0, 48'(ts - prev)};
			if (rate > 64'h0000_0000_FFFF_FFFF)
				rate = 64'h0000_0000_FFFF_FFFF;
		end
		if (audio == KIND_AUDIO) begin
			if (rate[31:0] > audio_peak)
				audio_peak = rate[31:0];
			last_audio_ts = ts;
			audio_count = audio_count + 32'd1;
		end else begin
			if (rate[31:0] > video_peak)
				video_peak = rate[31:0];
			last_video_ts = ts;
			video_count = video_count + 32'd1;
		end
		e.chunk_id      = (audio == KIND_AUDIO) ? aci_pkg::TAG_AUDIO : aci_pkg::TAG_VIDEO;
		e.key_flags     = (probe == aci_pkg::KEY_PROBE) ? aci_pkg::KEY_FLAG : 5'd0;
		e.chunk_offset  = byte_count + aci_pkg::OFFSET_BIAS;
		e.chunk_size    = bytes;
		e.pad_byte      = bytes[0];
		byte_count      = byte_count + aci_pkg::CHUNK_HDR + bytes + {31'd0, bytes[0]};
		e.bytes_total   = byte_count;
		e.video_frames  = video_count;
		e.audio_frames  = audio_count;
		e.peak_rate_sum = {1'b0, audio_peak} + {1'b0, video_peak};
		return e;
	endfunction

	// mostly short gaps, some long ones, and gap-free stretches
	function automatic int pick_gap(input int n);
		int r;
		r = $urandom_range(0, 99);
		if (n % 150 < 30 || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// offer one frame, wait for acceptance, queue its expected entry
	task automatic send_frame(input logic audio, input logic [47:0] ts,
			input logic [31:0] bytes, input logic [7:0] probe,
			input logic typed, input index_entry_t typed_entry);
		int gap;
		index_entry_t predicted;
		gap = pick_gap(sent);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		is_audio     <= audio;
		timestamp_us <= ts;
		frame_bytes  <= bytes;
		probe_byte   <= probe;
		do @(posedge clk); while (in_stall);
		predicted = index_frame(audio, ts, bytes, probe);
		pending_entries.push_back(typed ? typed_entry : predicted);
		sent++;
	endtask

	// stop offering and let every entry come back
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_offset(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		byte_count = value;
	endtask

	// stimulus
	initial begin
		logic [31:0] offsets [PHASES];
		logic [47:0] clock_a;
		logic [47:0] clock_v;
		logic [63:0] wide;
		logic        audio;
		logic [47:0] ts;
		logic [31:0] bytes;
		logic [7:0]  probe;
		int          r;

		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		is_audio     <= 1'b0;
		timestamp_us <= '0;
		frame_bytes  <= '0;
		probe_byte   <= '0;
		last_audio_ts = '0;
		last_video_ts = '0;
		audio_peak    = '0;
		video_peak    = '0;
		byte_count    = '0;
		audio_count   = '0;
		video_count   = '0;
		offsets = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'hFFFF_FFF0};
		clock_a = 48'($urandom_range(2000, 1000000));
		clock_v = 48'($urandom_range(2000, 1000000));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at the reset offset
		for (int i = 0; i < LEAD_ROWS; i++)
			send_frame(frame_plan[i].audio, frame_plan[i].ts, frame_plan[i].bytes,
				frame_plan[i].probe, frame_plan[i].typed, frame_plan[i].entry);

		// random phases, one start offset each
		for (int p = 0; p < PHASES; p++) begin
			drain_and_settle();
			write_start_offset(offsets[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r     = $urandom_range(0, 99);
				audio = 1'($urandom_range(0, 1));
				probe = ($urandom_range(0, 3) == 0) ? aci_pkg::KEY_PROBE : 8'($urandom);
				if (r < 82) begin
					// well-formed stream: rising time, size cap grows with the run
					if (audio == KIND_AUDIO) begin
						clock_a = clock_a + 48'($urandom_range(500, 40000));
						ts = clock_a;
					end else begin
						clock_v = clock_v + 48'($urandom_range(500, 40000));
						ts = clock_v;
					end
					bytes = $urandom_range(0, 1000 + sent * 1000);
				end else if (r < 88) begin
					ts    = '0;
					bytes = $urandom;
				end else if (r < 94) begin
					// repeated or backward time
					ts    = ((audio == KIND_AUDIO) ? clock_a : clock_v)
						- 48'($urandom_range(0, 1000));
					bytes = $urandom_range(0, 100000);
				end else begin
					wide  = {$urandom, $urandom};
					ts    = wide[47:0];
					bytes = $urandom;
					probe = 8'($urandom);
				end
				send_frame(audio, ts, bytes, probe, 1'b0, '0);
			end
		end

		// saturating frames
		for (int i = LEAD_ROWS; i < PLAN_ROWS; i++)
			send_frame(frame_plan[i].audio, frame_plan[i].ts, frame_plan[i].bytes,
				frame_plan[i].probe, frame_plan[i].typed, frame_plan[i].entry);

		drain_and_settle();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// result side: check each accepted entry, drive random stall
	initial begin
		int           hold_left;
		logic         pressed;
		logic         nxt;
		int           r;
		index_entry_t want;
		hold_left = 0;
		pressed   = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				taken++;
				if (pending_entries.size() == 0) begin
					$error("index entry with no frame pending");
					mismatches++;
				end else begin
					want = pending_entries.pop_front();
					check_field("chunk_id", want.chunk_id, chunk_id);
					check_field("key_flags", want.key_flags, key_flags);
					check_field("chunk_offset", want.chunk_offset, chunk_offset);
					check_field("chunk_size", want.chunk_size, chunk_size);
					check_field("pad_byte", want.pad_byte, pad_byte);
					check_field("bytes_total", want.bytes_total, bytes_total);
					check_field("video_frames", want.video_frames, video_frames);
					check_field("audio_frames", want.audio_frames, audio_frames);
					check_field("peak_rate_sum", want.peak_rate_sum, peak_rate_sum);
				end
			end
			// long hold once, so the block backs up into its input
			if (hold_left > 0) begin
				nxt = 1'b1;
				hold_left--;
			end else if (!pressed && taken >= HOLD_AFTER) begin
				pressed   = 1'b1;
				hold_left = HOLD_CYCLES;
				nxt       = 1'b1;
			end else if (taken % 200 < 40) begin
				nxt = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					nxt = 1'b0;
				end else if (r < 92) begin
					nxt       = 1'b1;
					hold_left = $urandom_range(0, 3);
				end else begin
					nxt       = 1'b1;
					hold_left = $urandom_range(10, 60);
				end
			end
			out_stall <= nxt;
		end
	end

	// watchdog: cycles with no handshake on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule
